// ----- rtl/acpi_rsdp_pkg.sv -----
// ----------------------------------------------------------------------------
// ACPI RSDP scanner package
// Window geometry, signature bytes and register widths shared by the scanner
// and its checker.
// ----------------------------------------------------------------------------
package acpi_rsdp_pkg;

    localparam int WIN_LEN  = 36;   // bytes in one RSDP structure (revision 2)
    localparam int BASE_LEN = 20;   // bytes covered by the revision 0 checksum
    localparam int REV_OFS  = 15;   // offset of the revision byte
    localparam int RSDT_OFS = 16;   // offset of the 32-bit RSDT address
    localparam int SIG_LEN  = 8;

    localparam int FILL_W   = 6;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);

    localparam int REGION_W = 20;
    localparam logic [REGION_W-1:0] REGION_END_RESET = 20'hFFFFF;

    localparam logic [7:0] MIN_EXT_REVISION = 8'd2;

    // "RSD PTR " in memory order.
    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
    };

    // Index 0 holds the oldest byte of the window.
    typedef logic [7:0] window_t [WIN_LEN];

    // Output tuser bit positions.
    localparam int USER_FOUND = 0;
    localparam int USER_DONE  = 1;
    localparam int OUT_USER_W = 2;

endpackage

// ----- rtl/acpi_rsdp_scanner.sv -----
// ----------------------------------------------------------------------------
// ACPI RSDP scanner
// Searches a stream of memory bytes for the first valid RSDP structure.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one memory byte per transfer with its address;
//   addresses must rise by one per transfer. A tuser bit of 1 restarts the
//   search: the 36-byte window and the done flag are cleared before that
//   byte is taken. Every input transfer yields exactly one output transfer,
//   in order. The output reports whether this byte completed the first valid
//   RSDP, the sticky done flag, and the start address, revision and RSDT
//   address of the last structure found (zero before any match).
//   The cfg channel writes region_end and is always ready; write it only
//   while no item is in flight.
//   An input transfer is captured in the input register and then, when the
//   output register is free, processed into the output register. One item is
//   taken per cycle while the receiver keeps up: the window shift and the
//   running checksum updates form one register-to-register step. An input
//   register and an output register decouple the two sides, so a stalled
//   receiver backs up into the input register and then drops s_tready. Reset
//   clears the window, both sums, the flags and the held results.
// ----------------------------------------------------------------------------
module acpi_rsdp_scanner
    import acpi_rsdp_pkg::*;
#(
    parameter int ADDR_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: data_byte[7:0], byte_address[ADDR_BITS+7:8], zero padding
    input  logic [((8+ADDR_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: restart
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: rsdp_address[ADDR_BITS-1:0], revision (8), rsdt_address (32),
    // zero padding
    output logic [((ADDR_BITS+40+7)/8)*8-1:0] m_tdata,
    // m_tuser: found, search_done
    output logic [OUT_USER_W-1:0] m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REGION_W-1:0]   cfg_data
);

    localparam int OUT_W = ((ADDR_BITS + 40 + 7) / 8) * 8;
    localparam int CMP_W = ((ADDR_BITS > REGION_W) ? ADDR_BITS : REGION_W) + 1;

    // Configuration
    logic [REGION_W-1:0] region_end_reg;

    // Input register
    logic                 item_valid_reg, item_valid_next;
    logic [7:0]           item_data_reg;
    logic [ADDR_BITS-1:0] item_addr_reg;
    logic                 item_restart_reg;

    // Scan state
    window_t              window_reg, window_next;
    logic [7:0]           sum20_reg, sum20_next;
    logic [7:0]           sum36_reg, sum36_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 found_flag_reg, found_flag_next;

    // Output register and held results
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [ADDR_BITS-1:0] held_addr_reg, held_addr_next;
    logic [7:0]           held_rev_reg, held_rev_next;
    logic [31:0]          held_rsdt_reg, held_rsdt_next;

    logic s_accept, advance, process;

    window_t              base_win;
    logic [7:0]           base_sum20, base_sum36;
    logic [FILL_W-1:0]    base_fill;
    logic                 base_found;
    logic                 sig_ok, in_region, hit;
    logic [ADDR_BITS-1:0] start_addr;

    assign cfg_ready = 1'b1;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = item_valid_reg && advance;
    assign s_tready = !item_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
            item_valid_next = 1'b1;
        else if (process)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    // A restart clears the state as seen by the byte that carries it.
    always_comb
    begin
        if (item_restart_reg)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                base_win[i] = 8'h00;
            base_sum20 = 8'h00;
            base_sum36 = 8'h00;
            base_fill  = '0;
            base_found = 1'b0;
        end
        else
        begin
            base_win   = window_reg;
            base_sum20 = sum20_reg;
            base_sum36 = sum36_reg;
            base_fill  = fill_reg;
            base_found = found_flag_reg;
        end
    end

    // Shift in the new byte and update the running sums by what enters and
    // leaves each span, so no adder tree over the window is needed.
    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
            window_next[i] = base_win[i+1];
        window_next[WIN_LEN-1] = item_data_reg;
        sum20_next = base_sum20 - base_win[0] + base_win[BASE_LEN];
        sum36_next = base_sum36 - base_win[0] + item_data_reg;
        fill_next  = (base_fill == FILL_FULL) ? base_fill : base_fill + 1'b1;
    end

    always_comb
    begin
        sig_ok = 1'b1;
        for (int i = 0; i < SIG_LEN; i++)
            if (window_next[i] != SIG_BYTES[i])
                sig_ok = 1'b0;
    end

    assign start_addr = item_addr_reg - ADDR_BITS'(WIN_LEN - 1);
    assign in_region  = (CMP_W'(start_addr) + CMP_W'(WIN_LEN)) < CMP_W'(region_end_reg);

    assign hit = !base_found && (fill_next == FILL_FULL) && sig_ok && in_region
              && (sum20_next == 8'h00)
              && ((window_next[REV_OFS] < MIN_EXT_REVISION) || (sum36_next == 8'h00));

    assign found_flag_next = base_found || hit;

    always_comb
    begin
        if (process)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        out_found_next = hit;
        if (hit)
        begin
            held_addr_next = start_addr;
            held_rev_next  = window_next[REV_OFS];
            held_rsdt_next = {window_next[RSDT_OFS+3], window_next[RSDT_OFS+2],
                              window_next[RSDT_OFS+1], window_next[RSDT_OFS]};
        end
        else
        begin
            held_addr_next = held_addr_reg;
            held_rev_next  = held_rev_reg;
            held_rsdt_next = held_rsdt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_end_reg <= REGION_END_RESET;
        else if (cfg_valid && cfg_ready)
            region_end_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_data_reg    <= s_tdata[7:0];
            item_addr_reg    <= s_tdata[8 +: ADDR_BITS];
            item_restart_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                window_reg[i] <= 8'h00;
            sum20_reg      <= 8'h00;
            sum36_reg      <= 8'h00;
            fill_reg       <= '0;
            found_flag_reg <= 1'b0;
            out_found_reg  <= 1'b0;
            held_addr_reg  <= '0;
            held_rev_reg   <= 8'h00;
            held_rsdt_reg  <= 32'h0;
        end
        else if (process)
        begin
            window_reg     <= window_next;
            sum20_reg      <= sum20_next;
            sum36_reg      <= sum36_next;
            fill_reg       <= fill_next;
            found_flag_reg <= found_flag_next;
            out_found_reg  <= out_found_next;
            held_addr_reg  <= held_addr_next;
            held_rev_reg   <= held_rev_next;
            held_rsdt_reg  <= held_rsdt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign m_tvalid            = out_valid_reg;
    assign m_tuser[USER_FOUND] = out_found_reg;
    assign m_tuser[USER_DONE]  = found_flag_reg;
    assign m_tdata             = OUT_W'({held_rsdt_reg, held_rev_reg, held_addr_reg});

endmodule

// ----- rtl/acpi_rsdp_checker.sv -----
// ----------------------------------------------------------------------------
// ACPI RSDP scanner checker
// Port-level assertions on the scanner, attached by a bind statement.
// ----------------------------------------------------------------------------
module acpi_rsdp_checker
    import acpi_rsdp_pkg::*;
#(
    parameter int ADDR_BITS = 20
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [((ADDR_BITS+40+7)/8)*8-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    localparam int HELD_W = ADDR_BITS + 40;

    logic              last_valid_reg;
    logic [HELD_W-1:0] last_held_reg;

    // Remember the held results of the last output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
            last_held_reg  <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_valid_reg <= 1'b1;
            last_held_reg  <= m_tdata[HELD_W-1:0];
        end
    end

    a_found_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_FOUND] |-> m_tuser[USER_DONE])
        else $error("found reported without search_done");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && last_valid_reg && !m_tuser[USER_FOUND]
            |-> m_tdata[HELD_W-1:0] == last_held_reg)
        else $error("held results changed without a match");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted byte produced no result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped during a stall");

endmodule

bind acpi_rsdp_scanner acpi_rsdp_checker #(.ADDR_BITS(ADDR_BITS)) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
